// ===== hw/rtl/etu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_pkg: shared types and constants for the eligibility trace update
// Stage numbers of the pipeline, trace formats, register codes and the
// rounding and saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package etu_pkg;

  // Trace format: signed Q8.16 in 24 bits, three traces per memory word
  localparam int TW    = 24;
  localparam int MEM_W = 3 * TW;
  localparam int WW    = 64;

  // Slot positions of the traces inside one memory word
  localparam int EV_LSB = 2 * TW;
  localparam int EA_LSB = TW;
  localparam int EL_LSB = 0;

  // Stage where each step of the update happens
  localparam int ST_EV  = 1;  // voltage trace
  localparam int ST_MA  = 2;  // adaptation coefficient product, psi * ev
  localparam int ST_CO  = 3;  // coefficient, cross term, (1-alpha) * ev
  localparam int ST_EA  = 4;  // adaptation trace
  localparam int ST_BEA = 5;  // beta * ea
  localparam int ST_IN  = 6;  // inner term
  localparam int ST_PR  = 7;  // psi * inner
  localparam int ST_EL  = 8;  // eligibility trace
  localparam int ST_WR  = 9;  // memory write and result

  // A read sees stale data for the items up to ST_WR ahead of it
  localparam int NFWD   = ST_WR;
  localparam int ST_END = ST_EL + NFWD;

  localparam logic signed [WW-1:0] TR_MAX = 64'sd8388607;
  localparam logic signed [WW-1:0] TR_MIN = -64'sd8388608;

  // Register reset values
  localparam logic [15:0] RST_VDECAY = 16'd62346;
  localparam logic [15:0] RST_VGAIN  = 16'd3190;
  localparam logic [15:0] RST_ADECAY = 16'd65209;
  localparam logic [15:0] RST_AGAIN  = 16'd327;
  localparam logic [15:0] RST_CROSS  = 16'd16;
  localparam logic [15:0] RST_ODECAY = 16'd62346;
  localparam logic        RST_FILTER = 1'b1;
  localparam logic        RST_RECUR  = 1'b0;

  typedef enum logic [2:0] {
    CFG_VDECAY = 3'd0,
    CFG_VGAIN  = 3'd1,
    CFG_ADECAY = 3'd2,
    CFG_AGAIN  = 3'd3,
    CFG_CROSS  = 3'd4,
    CFG_ODECAY = 3'd5,
    CFG_FILTER = 3'd6,
    CFG_RECUR  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] voltage_decay;
    logic [15:0] voltage_gain;
    logic [15:0] adapt_decay;
    logic [15:0] adapt_gain;
    logic [15:0] cross_gain;
    logic [15:0] out_decay;
    logic        filter_mode;
    logic        recurrent_layer;
  } cfg_t;

  // Round to nearest, ties toward plus infinity: add half, then floor
  function automatic logic signed [WW-1:0] rnd_shift(input logic signed [WW-1:0] v,
                                                     input int unsigned sh);
    logic signed [WW-1:0] half;
    half = '0;
    half[sh-1] = 1'b1;
    return (v + half) >>> sh;
  endfunction

  // Clamp to the trace range
  function automatic logic signed [TW-1:0] sat_trace(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    if (v > TR_MAX) begin
      r = TR_MAX;
    end else if (v < TR_MIN) begin
      r = TR_MIN;
    end else begin
      r = v;
    end
    return TW'(r);
  endfunction

endpackage

// ===== hw/rtl/etu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered, old data returned
// when a read and a write hit the same address in one cycle.
// ----------------------------------------------------------------------------
module etu_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, read-first
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/etu_fwd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_fwd: trace bypass selector
// Picks the newest in-flight value written to the same synapse, else the
// value read from the trace memory. Candidate 0 is the nearest item ahead.
// ----------------------------------------------------------------------------
module etu_fwd #(
  parameter int AW  = 14,
  parameter int DW  = 24,
  parameter int NUM = 9
) (
  input  logic [AW-1:0]           addr_i,
  input  logic [DW-1:0]           base_i,
  input  logic [NUM-1:0]          cand_en_i,
  input  logic [NUM-1:0][AW-1:0]  cand_addr_i,
  input  logic [NUM-1:0][DW-1:0]  cand_data_i,
  output logic [DW-1:0]           data_o
);

  // Scan from the oldest candidate so the nearest match wins
  always_comb begin
    data_o = base_i;
    for (int j = NUM - 1; j >= 0; j--) begin
      if (cand_en_i[j] && (cand_addr_i[j] == addr_i)) begin
        data_o = cand_data_i[j];
      end
    end
  end

endmodule

// ===== hw/rtl/etu_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_pipe: nine-stage trace update datapath
// Updates voltage, adaptation and eligibility traces of one synapse per
// clock, bypassing results of items still ahead of the memory write.
// ----------------------------------------------------------------------------
module etu_pipe #(
  parameter int AW = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  etu_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  input  logic                       in_write_i,
  input  logic                       in_kill_i,
  input  logic [AW-1:0]              in_addr_i,
  input  logic [6:0]                 in_pre_i,
  input  logic [6:0]                 in_post_i,
  input  logic signed [15:0]         in_act_i,
  input  logic signed [15:0]         in_psi_i,
  input  logic [15:0]                in_beta_i,
  input  logic [etu_pkg::MEM_W-1:0]  mem_rdata_i,
  output logic                       wr_en_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [etu_pkg::MEM_W-1:0]  wr_data_o,
  output logic                       res_valid_o,
  output logic [6:0]                 res_pre_o,
  output logic [6:0]                 res_post_o,
  output logic signed [etu_pkg::TW-1:0] res_elig_o
);

  localparam int TW   = etu_pkg::TW;
  localparam int NF   = etu_pkg::NFWD;
  localparam int SEV  = etu_pkg::ST_EV;
  localparam int SMA  = etu_pkg::ST_MA;
  localparam int SCO  = etu_pkg::ST_CO;
  localparam int SEA  = etu_pkg::ST_EA;
  localparam int SBEA = etu_pkg::ST_BEA;
  localparam int SIN  = etu_pkg::ST_IN;
  localparam int SPR  = etu_pkg::ST_PR;
  localparam int SEL  = etu_pkg::ST_EL;
  localparam int SWR  = etu_pkg::ST_WR;
  localparam int SEND = etu_pkg::ST_END;

  // Control flags per stage
  logic [SWR:1]  vld_q;
  logic [SEND:1] wen_q;
  logic [SEL:1]  kill_q;

  // Payload carried along the stages
  logic [AW-1:0]          addr_q [1:SEND];
  logic [6:0]             pre_q  [1:SWR];
  logic [6:0]             post_q [1:SWR];
  logic signed [15:0]     act_q;
  logic signed [15:0]     psi_q  [1:SPR];
  logic [15:0]            beta_q [1:SBEA];
  logic signed [TW-1:0]   mem_ea_q [SMA:SEA];
  logic signed [TW-1:0]   mem_el_q [SMA:SEL];
  logic signed [TW-1:0]   ev_q [SEV+1:SEV+NF];
  logic signed [TW-1:0]   ea_q [SEA+1:SEA+NF];
  logic signed [TW-1:0]   el_q [SEL+1:SEL+NF];
  logic [31:0]            gb_q;
  logic signed [48:0]     ma_q;
  logic signed [39:0]     t1_q;
  logic signed [29:0]     coef_q;
  logic signed [45:0]     crs_q;
  logic signed [40:0]     vgev_q [SEA:SIN];
  logic signed [40:0]     bea_q;
  logic signed [33:0]     inner_q;
  logic signed [49:0]     prod_q;

  // Next values of the computed stage registers
  logic signed [TW-1:0]   ev_d, ea_d, el_d;
  logic [31:0]            gb_d;
  logic signed [48:0]     ma_d;
  logic signed [39:0]     t1_d;
  logic signed [29:0]     coef_d;
  logic signed [45:0]     crs_d;
  logic signed [40:0]     vgev_d;
  logic signed [40:0]     bea_d;
  logic signed [33:0]     inner_d;
  logic signed [49:0]     prod_d;

  // Configuration as signed operands
  logic signed [16:0] vdecay_s, vgain_s, adecay_s, cross_s, dec_s;
  logic signed [32:0] gb_s;
  logic signed [16:0] beta_s;

  // Bypass candidates
  logic [NF-1:0]           ev_c_en, ea_c_en, el_c_en;
  logic [NF-1:0][AW-1:0]   ev_c_addr, ea_c_addr, el_c_addr;
  logic [NF-1:0][TW-1:0]   ev_c_data, ea_c_data, el_c_data;
  logic signed [TW-1:0]    ev_old, ea_old, el_old;

  // Products
  logic signed [40:0]      p_ev;
  logic signed [56:0]      p_cross;
  logic signed [53:0]      p_ea;
  logic signed [40:0]      p_el;

  assign vdecay_s = $signed({1'b0, cfg_i.voltage_decay});
  assign vgain_s  = $signed({1'b0, cfg_i.voltage_gain});
  assign adecay_s = $signed({1'b0, cfg_i.adapt_decay});
  assign cross_s  = $signed({1'b0, cfg_i.cross_gain});
  assign dec_s    = cfg_i.filter_mode ? $signed({1'b0, cfg_i.out_decay}) : '0;
  assign gb_s     = $signed({1'b0, gb_q});
  assign beta_s   = $signed({1'b0, beta_q[SBEA]});

  // Gather bypass candidates for each trace
  always_comb begin
    for (int j = 0; j < NF; j++) begin
      ev_c_en[j]   = wen_q[SEV + 1 + j];
      ev_c_addr[j] = addr_q[SEV + 1 + j];
      ev_c_data[j] = ev_q[SEV + 1 + j];
      ea_c_en[j]   = wen_q[SEA + 1 + j];
      ea_c_addr[j] = addr_q[SEA + 1 + j];
      ea_c_data[j] = ea_q[SEA + 1 + j];
      el_c_en[j]   = wen_q[SEL + 1 + j];
      el_c_addr[j] = addr_q[SEL + 1 + j];
      el_c_data[j] = el_q[SEL + 1 + j];
    end
  end

  etu_fwd #(.AW(AW), .DW(TW), .NUM(NF)) u_fwd_ev (
    .addr_i      (addr_q[SEV]),
    .base_i      (mem_rdata_i[etu_pkg::EV_LSB +: TW]),
    .cand_en_i   (ev_c_en),
    .cand_addr_i (ev_c_addr),
    .cand_data_i (ev_c_data),
    .data_o      (ev_old)
  );

  etu_fwd #(.AW(AW), .DW(TW), .NUM(NF)) u_fwd_ea (
    .addr_i      (addr_q[SEA]),
    .base_i      (mem_ea_q[SEA]),
    .cand_en_i   (ea_c_en),
    .cand_addr_i (ea_c_addr),
    .cand_data_i (ea_c_data),
    .data_o      (ea_old)
  );

  etu_fwd #(.AW(AW), .DW(TW), .NUM(NF)) u_fwd_el (
    .addr_i      (addr_q[SEL]),
    .base_i      (mem_el_q[SEL]),
    .cand_en_i   (el_c_en),
    .cand_addr_i (el_c_addr),
    .cand_data_i (el_c_data),
    .data_o      (el_old)
  );

  // Stage 1: voltage trace, adapt gain times beta
  assign p_ev = vdecay_s * ev_old;
  assign ev_d = kill_q[SEV] ? '0 :
                etu_pkg::sat_trace(etu_pkg::rnd_shift(64'(p_ev), 16) + (64'(act_q) <<< 8));
  assign gb_d = {16'b0, cfg_i.adapt_gain} * {16'b0, beta_q[SEV]};

  // Stage 2: full coefficient product, psi times voltage trace
  assign ma_d = gb_s * psi_q[SMA];
  assign t1_d = psi_q[SMA] * ev_q[SMA];

  // Stage 3: coefficient, rounded cross term, (1-alpha) times voltage trace
  assign coef_d  = 30'(64'(adecay_s) - etu_pkg::rnd_shift(64'(ma_q), 20));
  assign p_cross = t1_q * cross_s;
  assign crs_d   = 46'(etu_pkg::rnd_shift(64'(p_cross), 12));
  assign vgev_d  = vgain_s * ev_q[SCO];

  // Stage 4: adaptation trace
  assign p_ea = coef_q * ea_old;
  assign ea_d = kill_q[SEA] ? '0 :
                etu_pkg::sat_trace(etu_pkg::rnd_shift(64'(p_ea) + 64'(crs_q), 16));

  // Stage 5: beta times adaptation trace
  assign bea_d = beta_s * ea_q[SBEA];

  // Stage 6: inner term
  assign inner_d = 34'(etu_pkg::rnd_shift(64'(vgev_q[SIN]) - (64'(bea_q) <<< 8), 16));

  // Stage 7: psi times inner term
  assign prod_d = psi_q[SPR] * inner_q;

  // Stage 8: eligibility trace
  assign p_el = dec_s * el_old;
  assign el_d = kill_q[SEL] ? '0 :
                etu_pkg::sat_trace(etu_pkg::rnd_shift(64'(p_el) + (64'(prod_q) <<< 4), 16));

  // Advance control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      wen_q  <= '0;
      kill_q <= '0;
    end else begin
      vld_q  <= {vld_q[SWR-1:1], in_valid_i};
      wen_q  <= {wen_q[SEND-1:1], in_valid_i & in_write_i};
      kill_q <= {kill_q[SEL-1:1], in_kill_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    addr_q[1] <= in_addr_i;
    for (int k = 2; k <= SEND; k++) begin
      addr_q[k] <= addr_q[k-1];
    end
    pre_q[1]  <= in_pre_i;
    post_q[1] <= in_post_i;
    for (int k = 2; k <= SWR; k++) begin
      pre_q[k]  <= pre_q[k-1];
      post_q[k] <= post_q[k-1];
    end
    act_q     <= in_act_i;
    psi_q[1]  <= in_psi_i;
    for (int k = 2; k <= SPR; k++) begin
      psi_q[k] <= psi_q[k-1];
    end
    beta_q[1] <= in_beta_i;
    for (int k = 2; k <= SBEA; k++) begin
      beta_q[k] <= beta_q[k-1];
    end
    mem_ea_q[SMA] <= $signed(mem_rdata_i[etu_pkg::EA_LSB +: TW]);
    for (int k = SMA + 1; k <= SEA; k++) begin
      mem_ea_q[k] <= mem_ea_q[k-1];
    end
    mem_el_q[SMA] <= $signed(mem_rdata_i[etu_pkg::EL_LSB +: TW]);
    for (int k = SMA + 1; k <= SEL; k++) begin
      mem_el_q[k] <= mem_el_q[k-1];
    end
    ev_q[SEV+1] <= ev_d;
    for (int k = SEV + 2; k <= SEV + NF; k++) begin
      ev_q[k] <= ev_q[k-1];
    end
    ea_q[SEA+1] <= ea_d;
    for (int k = SEA + 2; k <= SEA + NF; k++) begin
      ea_q[k] <= ea_q[k-1];
    end
    el_q[SEL+1] <= el_d;
    for (int k = SEL + 2; k <= SEL + NF; k++) begin
      el_q[k] <= el_q[k-1];
    end
    gb_q    <= gb_d;
    ma_q    <= ma_d;
    t1_q    <= t1_d;
    coef_q  <= coef_d;
    crs_q   <= crs_d;
    vgev_q[SEA] <= vgev_d;
    for (int k = SEA + 1; k <= SIN; k++) begin
      vgev_q[k] <= vgev_q[k-1];
    end
    bea_q   <= bea_d;
    inner_q <= inner_d;
    prod_q  <= prod_d;
  end

  // Write back and present the result
  assign wr_en_o     = wen_q[SWR];
  assign wr_addr_o   = addr_q[SWR];
  assign wr_data_o   = {ev_q[SWR], ea_q[SWR], el_q[SWR]};
  assign res_valid_o = vld_q[SWR];
  assign res_pre_o   = pre_q[SWR];
  assign res_post_o  = post_q[SWR];
  assign res_elig_o  = wen_q[SWR] ? el_q[SWR] : '0;

endmodule

// ===== hw/rtl/eligibility_trace_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eligibility_trace_update: per-synapse e-prop trace update for ALIF neurons
// Keeps voltage, adaptation and eligibility traces for every synapse and
// returns the new eligibility trace of each synapse request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter with start while busy is low; each names a synapse by
//   pre_index_i and post_index_i and carries activity, psi and beta.
//   A result appears on out_pre_index_o, out_post_index_o and eligibility_o
//   for one cycle, marked by res_valid_o, when the request reaches the
//   write-back stage. One request may be taken every clock cycle; the
//   rate is one synapse per cycle, set by the single read port and single
//   write port of the trace memory. Back-to-back requests to the same synapse
//   are resolved by bypassing the newest values still in flight.
//   The receiver cannot stall; results are never held.
//   After reset the trace memory is cleared one entry per cycle, through all
//   N_PRE * N_POST entries (16384 at the defaults); busy stays high meanwhile.
//   Configuration registers are written through cfg_we_i, cfg_index_i and
//   cfg_data_i with no wait; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module eligibility_trace_update #(
  parameter int N_PRE  = 128,
  parameter int N_POST = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [6:0]         pre_index_i,
  input  logic [6:0]         post_index_i,
  input  logic signed [15:0] pre_activity_i,
  input  logic signed [15:0] pseudo_derivative_i,
  input  logic [15:0]        threshold_gain_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               res_valid_o,
  output logic [6:0]         out_pre_index_o,
  output logic [6:0]         out_post_index_o,
  output logic signed [23:0] eligibility_o
);

  localparam int DEPTH = N_PRE * N_POST;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = etu_pkg::MEM_W;

  etu_pkg::cfg_t  cfg_q;
  logic           clearing_q;
  logic [AW-1:0]  clr_cnt_q;

  logic           in_valid, in_range, in_kill;
  logic [AW-1:0]  in_addr;
  logic           pipe_we;
  logic [AW-1:0]  pipe_waddr;
  logic [MW-1:0]  pipe_wdata;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [MW-1:0]  ram_wdata;
  logic [MW-1:0]  ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_decay   <= etu_pkg::RST_VDECAY;
      cfg_q.voltage_gain    <= etu_pkg::RST_VGAIN;
      cfg_q.adapt_decay     <= etu_pkg::RST_ADECAY;
      cfg_q.adapt_gain      <= etu_pkg::RST_AGAIN;
      cfg_q.cross_gain      <= etu_pkg::RST_CROSS;
      cfg_q.out_decay       <= etu_pkg::RST_ODECAY;
      cfg_q.filter_mode     <= etu_pkg::RST_FILTER;
      cfg_q.recurrent_layer <= etu_pkg::RST_RECUR;
    end else if (cfg_we_i) begin
      unique case (etu_pkg::cfg_idx_e'(cfg_index_i))
        etu_pkg::CFG_VDECAY: cfg_q.voltage_decay   <= cfg_data_i;
        etu_pkg::CFG_VGAIN:  cfg_q.voltage_gain    <= cfg_data_i;
        etu_pkg::CFG_ADECAY: cfg_q.adapt_decay     <= cfg_data_i;
        etu_pkg::CFG_AGAIN:  cfg_q.adapt_gain      <= cfg_data_i;
        etu_pkg::CFG_CROSS:  cfg_q.cross_gain      <= cfg_data_i;
        etu_pkg::CFG_ODECAY: cfg_q.out_decay       <= cfg_data_i;
        etu_pkg::CFG_FILTER: cfg_q.filter_mode     <= cfg_data_i[0];
        etu_pkg::CFG_RECUR:  cfg_q.recurrent_layer <= cfg_data_i[0];
      endcase
    end
  end

  // Sweep the trace memory to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign busy = clearing_q;

  // Decode the request: range check, self-synapse, memory address
  assign in_valid = start && !busy;
  assign in_range = (int'(pre_index_i) < N_PRE) && (int'(post_index_i) < N_POST);
  assign in_kill  = in_range && cfg_q.recurrent_layer && (pre_index_i == post_index_i);
  assign in_addr  = in_range ? AW'(int'(pre_index_i) * N_POST + int'(post_index_i)) : '0;

  etu_pipe #(.AW(AW)) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid),
    .in_write_i  (in_range),
    .in_kill_i   (in_kill),
    .in_addr_i   (in_addr),
    .in_pre_i    (pre_index_i),
    .in_post_i   (post_index_i),
    .in_act_i    (pre_activity_i),
    .in_psi_i    (pseudo_derivative_i),
    .in_beta_i   (threshold_gain_i),
    .mem_rdata_i (ram_rdata),
    .wr_en_o     (pipe_we),
    .wr_addr_o   (pipe_waddr),
    .wr_data_o   (pipe_wdata),
    .res_valid_o (res_valid_o),
    .res_pre_o   (out_pre_index_o),
    .res_post_o  (out_post_index_o),
    .res_elig_o  (eligibility_o)
  );

  // Select the memory writer: clearing sweep or pipeline write-back
  assign ram_we    = clearing_q || pipe_we;
  assign ram_waddr = clearing_q ? clr_cnt_q : pipe_waddr;
  assign ram_wdata = clearing_q ? '0 : pipe_wdata;

  etu_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_trace_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== hw/rtl/etu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_checker: port-level checks for the eligibility trace update
// Watches request and result ports for fixed latency, the one-time clearing
// pass and zero results for synapses outside the array.
// ----------------------------------------------------------------------------
module etu_checker #(
  parameter int N_PRE  = 128,
  parameter int N_POST = 128
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [6:0]         pre_index_i,
  input logic [6:0]         post_index_i,
  input logic               res_valid_o,
  input logic [6:0]         out_pre_index_o,
  input logic [6:0]         out_post_index_o,
  input logic signed [23:0] eligibility_o
);

  localparam int LAT = etu_pkg::ST_WR;

  // Every request gives a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT res_valid_o)
    else $error("request without result");

  // No result without a request
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, LAT))
    else $error("result without request");

  // Result carries the synapse of its request
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (out_pre_index_o == $past(pre_index_i, LAT)) &&
                    (out_post_index_o == $past(post_index_i, LAT)))
    else $error("synapse index mismatch");

  // Clearing happens once after reset
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose again");

  // Synapses outside the array give zero
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && ((int'(out_pre_index_o) >= N_PRE) || (int'(out_post_index_o) >= N_POST)))
      |-> (eligibility_o == '0))
    else $error("nonzero result for synapse outside the array");

endmodule

bind eligibility_trace_update etu_checker #(
  .N_PRE  (N_PRE),
  .N_POST (N_POST)
) u_etu_checker (.*);
